// ===== design/ccm_pkg.sv =====
// ----------------------------------------------------------------------------
// ccm_pkg: shared types and constants for the coulomb counter
// Beat structs, register index codes, sequencer states and datapath widths.
// ----------------------------------------------------------------------------
package ccm_pkg;

  localparam int TIME_W       = 32;
  localparam int CODE_W       = 12;
  localparam int DUTY_W       = 8;
  localparam int GAIN_W       = 24;
  localparam int THR_W        = 32;
  localparam int COEF_W       = 32;
  localparam int CURRENT_W    = 40;
  localparam int CHARGE_W     = 63;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  // shared multiplier: signed A x signed B, low MUL_P_W bits kept
  localparam int MUL_A_W      = 64;
  localparam int MUL_B_W      = 17;
  localparam int MUL_P_W      = 64;
  localparam int HALF_T_W     = TIME_W / 2;
  localparam int PART_W       = CURRENT_W + TIME_W;

  localparam int POLY_TERMS_DEF = 4;
  localparam int ADC_BITS_DEF   = 12;

  localparam logic [CURRENT_W-1:0] CURRENT_MAX = '1;
  localparam logic [CHARGE_W-1:0]  CHARGE_MAX  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODEL_READY = 3'd0,
    REG_CURRENT_GAIN = 3'd1,
    REG_LOW_THR = 3'd2,
    REG_COEF0 = 3'd3,
    REG_COEF1 = 3'd4,
    REG_COEF2 = 3'd5,
    REG_COEF3 = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAS,
    S_CMP,
    S_HMUL,
    S_HADD,
    S_CLAMP,
    S_MLO,
    S_MHI,
    S_MSUM,
    S_ACC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [CODE_W-1:0] current_code;
    logic [DUTY_W-1:0] pwm_duty;
  } in_beat_t;

  typedef struct packed {
    logic [CHARGE_W-1:0]  charge_total;
    logic [CURRENT_W-1:0] current_used;
    logic                 estimated;
  } out_beat_t;

  typedef struct packed {
    logic               model_ready;
    logic [GAIN_W-1:0]  current_gain;
    logic [THR_W-1:0]   low_current_threshold;
  } cfg_t;

endpackage

// ===== design/coulomb_counter_with_model.sv =====
// ----------------------------------------------------------------------------
// coulomb_counter_with_model: charge counter with low-current duty model
// Sequencer around one shared multiplier; saturating Q47.16 mA*ms charge.
// ----------------------------------------------------------------------------
// An input beat runs through measure (code*gain) and compare, then, when the
// duty-cycle polynomial replaces the measured current, the Horner steps and a
// clamp, then the two halves of current*elapsed, accumulate and done; a
// stalled result slot holds the beat in done until it frees. The single 64x17
// multiplier does all products: one pass for code*gain, one per Horner step, and
// two for current*elapsed, split in 16-bit halves of the elapsed time. The
// input stalls while a beat is in work; the result register lets the next
// beat in while the previous result waits. Charge saturates at 2^63-1 and
// stays there; divide by 3.6e6 * 65536 for mAh. The first beat after reset
// measures elapsed time from time zero. Configuration is write-only and must
// be changed only while idle.
// ----------------------------------------------------------------------------
module coulomb_counter_with_model #(
  parameter int POLY_TERMS = ccm_pkg::POLY_TERMS_DEF,
  parameter int ADC_BITS   = ccm_pkg::ADC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input beats
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ccm_pkg::in_beat_t              in_beat,
  // result beats
  output logic                           out_valid,
  input  logic                           out_stall,
  output ccm_pkg::out_beat_t             out_beat,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [ccm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ccm_pkg::*;

  // effective ADC code width; upper code bits are dropped
  localparam int CODE_EFF = (ADC_BITS < CODE_W) ? ADC_BITS : CODE_W;
  localparam int CIDX_W   = (POLY_TERMS > 1) ? $clog2(POLY_TERMS) : 1;
  localparam logic [CIDX_W-1:0] STEP_TOP =
    CIDX_W'((POLY_TERMS > 1) ? POLY_TERMS - 2 : 0);

  cfg_t                              cfg;
  logic [POLY_TERMS-1:0][COEF_W-1:0] coef;

  ccm_cfg #(.POLY_TERMS(POLY_TERMS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg),
    .coef_o    (coef)
  );

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  ccm_mul u_mul (
    .clk    (clk),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  state_t                    state_r, state_nxt;
  logic [TIME_W-1:0]         last_time_r, last_time_nxt;
  logic [TIME_W-1:0]         elapsed_r, elapsed_nxt;
  logic [CODE_EFF-1:0]       code_r, code_nxt;
  logic [DUTY_W-1:0]         duty_r, duty_nxt;
  logic signed [MUL_P_W-1:0] acc_r, acc_nxt;       // Horner accumulator
  logic [CIDX_W-1:0]         step_r, step_nxt;
  logic [CURRENT_W-1:0]      current_r, current_nxt;
  logic                      est_r, est_nxt;
  logic [PART_W-1:0]         part_r, part_nxt;     // current * elapsed
  logic [CHARGE_W-1:0]       charge_r, charge_nxt;
  out_beat_t                 out_r, out_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic                      in_acc;
  logic                      slot_free;
  logic [CURRENT_W-1:0]      meas;
  logic [PART_W:0]           sum;

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign meas      = prod[CURRENT_W-1:0];           // code*gain < 2^40
  assign sum       = (PART_W+1)'(charge_r) + (PART_W+1)'(part_r);

  always_comb begin
    state_nxt     = state_r;
    last_time_nxt = last_time_r;
    elapsed_nxt   = elapsed_r;
    code_nxt      = code_r;
    duty_nxt      = duty_r;
    acc_nxt       = acc_r;
    step_nxt      = step_r;
    current_nxt   = current_r;
    est_nxt       = est_r;
    part_nxt      = part_r;
    charge_nxt    = charge_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_a         = '0;
    mul_b         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          elapsed_nxt   = in_beat.now_ms - last_time_r;   // wrapping
          last_time_nxt = in_beat.now_ms;
          code_nxt      = in_beat.current_code[CODE_EFF-1:0];
          duty_nxt      = in_beat.pwm_duty;
          state_nxt     = S_MEAS;
        end
      end
      S_MEAS: begin
        mul_a     = MUL_A_W'(cfg.current_gain);
        mul_b     = MUL_B_W'(code_r);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (cfg.model_ready && meas < CURRENT_W'(cfg.low_current_threshold)) begin
          est_nxt   = 1'b1;
          acc_nxt   = MUL_P_W'(signed'(coef[POLY_TERMS-1]));
          step_nxt  = STEP_TOP;
          state_nxt = (POLY_TERMS > 1) ? S_HMUL : S_CLAMP;
        end else begin
          est_nxt     = 1'b0;
          current_nxt = meas;
          state_nxt   = S_MLO;
        end
      end
      S_HMUL: begin
        mul_a     = acc_r;
        mul_b     = MUL_B_W'(duty_r);
        state_nxt = S_HADD;
      end
      S_HADD: begin
        acc_nxt = prod + MUL_P_W'(signed'(coef[step_r]));
        if (step_r == '0) begin
          state_nxt = S_CLAMP;
        end else begin
          step_nxt  = step_r - 1'b1;
          state_nxt = S_HMUL;
        end
      end
      S_CLAMP: begin
        if (acc_r[MUL_P_W-1]) begin
          current_nxt = '0;
        end else if (|acc_r[MUL_P_W-2:CURRENT_W]) begin
          current_nxt = CURRENT_MAX;
        end else begin
          current_nxt = acc_r[CURRENT_W-1:0];
        end
        state_nxt = S_MLO;
      end
      S_MLO: begin
        mul_a     = MUL_A_W'(current_r);
        mul_b     = MUL_B_W'(elapsed_r[HALF_T_W-1:0]);
        state_nxt = S_MHI;
      end
      S_MHI: begin
        part_nxt  = PART_W'(prod[CURRENT_W+HALF_T_W-1:0]);
        mul_a     = MUL_A_W'(current_r);
        mul_b     = MUL_B_W'(elapsed_r[TIME_W-1:HALF_T_W]);
        state_nxt = S_MSUM;
      end
      S_MSUM: begin
        part_nxt  = part_r + {prod[CURRENT_W+HALF_T_W-1:0], {HALF_T_W{1'b0}}};
        state_nxt = S_ACC;
      end
      S_ACC: begin
        // saturate anything at or above 2^63
        if (|sum[PART_W:CHARGE_W]) begin
          charge_nxt = CHARGE_MAX;
        end else begin
          charge_nxt = sum[CHARGE_W-1:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          out_nxt.charge_total = charge_r;
          out_nxt.current_used = current_r;
          out_nxt.estimated    = est_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_time_r <= '0;
      charge_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_time_r <= last_time_nxt;
      charge_r    <= charge_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    code_r    <= code_nxt;
    duty_r    <= duty_nxt;
    acc_r     <= acc_nxt;
    step_r    <= step_nxt;
    current_r <= current_nxt;
    est_r     <= est_nxt;
    part_r    <= part_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  // accepted beat blocks the input on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepted beat");

  // charge never goes down
  a_charge_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> charge_r >= $past(charge_r))
    else $error("charge accumulator decreased");

  // a new result comes only out of the final sequencer step
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside final step");

endmodule

// ===== design/ccm_cfg.sv =====
// ----------------------------------------------------------------------------
// ccm_cfg: configuration register file
// Write-only registers; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module ccm_cfg #(
  parameter int POLY_TERMS = ccm_pkg::POLY_TERMS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ccm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ccm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output ccm_pkg::cfg_t                        cfg_o,
  output logic [POLY_TERMS-1:0][ccm_pkg::COEF_W-1:0] coef_o
);
  import ccm_pkg::*;

  cfg_t                          cfg_r;
  logic [POLY_TERMS-1:0][COEF_W-1:0] coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODEL_READY:  cfg_r.model_ready <= cfg_wdata[0];
        REG_CURRENT_GAIN: cfg_r.current_gain <= cfg_wdata[GAIN_W-1:0];
        REG_LOW_THR:      cfg_r.low_current_threshold <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // only the coefficients in use get storage
  for (genvar k = 0; k < POLY_TERMS; k++) begin : g_coef
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        coef_r[k] <= '0;
      end else if (cfg_we && cfg_index == CFG_IDX_W'(REG_COEF0 + k)) begin
        coef_r[k] <= cfg_wdata[COEF_W-1:0];
      end
    end
  end

  assign cfg_o  = cfg_r;
  assign coef_o = coef_r;

endmodule

// ===== design/ccm_mul.sv =====
// ----------------------------------------------------------------------------
// ccm_mul: shared signed multiplier, registered product
// 64 x 17 signed, low 64 bits of the product kept.
// ----------------------------------------------------------------------------
module ccm_mul (
  input  logic                              clk,
  input  logic signed [ccm_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [ccm_pkg::MUL_B_W-1:0] b_i,
  output logic signed [ccm_pkg::MUL_P_W-1:0] prod_o
);
  import ccm_pkg::*;

  logic signed [MUL_A_W+MUL_B_W-1:0] full;
  logic signed [MUL_P_W-1:0]         prod_r;

  assign full = a_i * b_i;

  always_ff @(posedge clk) begin
    prod_r <= full[MUL_P_W-1:0];
  end

  assign prod_o = prod_r;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for coulomb_counter_with_model
// A clocked driver feeds input beats from a queue and a clocked monitor checks
// every result beat against an in-bench charge predictor. Registers are
// rewritten between phases while the block is idle. The run covers directed
// corner cases (first beat after reset, wrap and backward timestamps, zero
// elapsed time, threshold edge, polynomial clamp and saturation), then random
// phases, ending with charge saturation.
// ----------------------------------------------------------------------------
module tb_top;
  import ccm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // no register behind it
  localparam int IDLE_PCT      = 17;   // idle chance per cycle, both sides
  localparam int HOLD_AT       = 60;   // beats in before the long hold-off
  localparam int HOLD_CYCLES   = 80;
  localparam int STEADY_LO     = 200;  // no idling while beats_in is in here
  localparam int STEADY_HI     = 300;
  localparam int SETTLE_CYCLES = 24;   // longer than the slowest sequencer pass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_beat_t              in_beat   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_beat;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always #1 clk = ~clk;

  coulomb_counter_with_model dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Predictor state: register shadows plus timestamp and charge.
  // --------------------------------------------------------------------------
  logic                mdl_ready;
  logic [GAIN_W-1:0]   mdl_gain;
  logic [THR_W-1:0]    mdl_thr;
  longint              mdl_coef [4];
  logic [TIME_W-1:0]   mdl_last_ms;
  logic [CHARGE_W-1:0] mdl_charge;

  in_beat_t  beats_to_send [$];  // stimulus not yet offered
  out_beat_t totals_due [$];     // predicted results, oldest first

  logic [TIME_W-1:0] stamp;      // running timestamp for generated beats
  logic in_took   = 1'b0;        // input beat accepted at the last rising edge
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   beats_in  = 0;
  int   results_seen = 0;
  int   from_model   = 0;
  int   pinned       = 0;
  int   mismatches   = 0;
  logic steady;

  assign steady = (beats_in >= STEADY_LO) && (beats_in < STEADY_HI);

  // Charge update for one accepted beat; advances the predictor state.
  function automatic out_beat_t tally_charge(input in_beat_t b);
    out_beat_t            r;
    logic [TIME_W-1:0]    elapsed;
    logic [CURRENT_W-1:0] amps;
    longint               horner;
    longint               duty;
    logic [127:0]         sum;
    elapsed     = b.now_ms - mdl_last_ms;  // wraps, backward steps included
    amps        = CURRENT_W'(b.current_code) * CURRENT_W'(mdl_gain);
    r.estimated = 1'b0;
    if (mdl_ready && amps < CURRENT_W'(mdl_thr)) begin
      // Horner on the duty cycle, exact in 64 bits, then clamp to 0..2^40-1
      duty   = {56'd0, b.pwm_duty};
      horner = mdl_coef[POLY_TERMS_DEF-1];
      for (int k = POLY_TERMS_DEF - 2; k >= 0; k--)
        horner = horner * duty + mdl_coef[k];
      if (horner < 0)
        amps = '0;
      else if (horner > 64'sh0000_00FF_FFFF_FFFF)
        amps = CURRENT_MAX;
      else
        amps = horner[CURRENT_W-1:0];
      r.estimated = 1'b1;
    end
    // exact wide sum; anything past 2^63-1 pins the accumulator
    sum = 128'(mdl_charge) + 128'(amps) * 128'(elapsed);
    mdl_charge     = (sum > 128'(CHARGE_MAX)) ? CHARGE_MAX : sum[CHARGE_W-1:0];
    mdl_last_ms    = b.now_ms;
    r.charge_total = mdl_charge;
    r.current_used = amps;
    return r;
  endfunction

  task automatic note_error(input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH: %s", what);
  endtask

  // One register write, issued at a falling edge; shadow follows.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODEL_READY:  mdl_ready   = val[0];
      REG_CURRENT_GAIN: mdl_gain    = val[GAIN_W-1:0];
      REG_LOW_THR:      mdl_thr     = val;
      REG_COEF0:        mdl_coef[0] = longint'(signed'(val));
      REG_COEF1:        mdl_coef[1] = longint'(signed'(val));
      REG_COEF2:        mdl_coef[2] = longint'(signed'(val));
      REG_COEF3:        mdl_coef[3] = longint'(signed'(val));
      default: ;  // spare index: block ignores it
    endcase
  endtask

  task automatic set_regs(input logic [31:0] ready, input logic [31:0] gain,
                          input logic [31:0] thr, input logic [31:0] c0,
                          input logic [31:0] c1, input logic [31:0] c2,
                          input logic [31:0] c3);
    write_reg(REG_MODEL_READY, ready);
    write_reg(REG_CURRENT_GAIN, gain);
    write_reg(REG_LOW_THR, thr);
    write_reg(REG_COEF0, c0);
    write_reg(REG_COEF1, c1);
    write_reg(REG_COEF2, c2);
    write_reg(REG_COEF3, c3);
  endtask

  task automatic queue_beat(input logic [TIME_W-1:0] now,
                            input logic [CODE_W-1:0] code,
                            input logic [DUTY_W-1:0] duty);
    in_beat_t b;
    b.now_ms       = now;
    b.current_code = code;
    b.pwm_duty     = duty;
    beats_to_send.push_back(b);
  endtask

  // Random beats up to step_max ms apart; wild_pct of them jump to any timestamp.
  task automatic queue_run(input int n, input int step_max, input int wild_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < wild_pct)
        stamp = $urandom;
      else
        stamp = stamp + $urandom_range(step_max);
      queue_beat(stamp, CODE_W'($urandom_range(4095)), DUTY_W'($urandom_range(255)));
    end
  endtask

  // Sender pause: everything offered, accepted and answered, then a margin
  // so the sequencer is back in idle before registers change.
  task automatic settle();
    while (beats_to_send.size() != 0 || in_valid || totals_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: new beat only when the slot is empty or the last one was taken.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (beats_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_beat  <= beats_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: random, one long hold-off that backs up the input side,
  // and a window with no stalls at all.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_in >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check result beats first, then predict for the accepted input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_beat_t want;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (totals_due.size() == 0) begin
        note_error($sformatf("unexpected result: charge %h current %h est %b",
                             out_beat.charge_total, out_beat.current_used,
                             out_beat.estimated));
      end else begin
        want = totals_due.pop_front();
        results_seen++;
        if (want.estimated) from_model++;
        if (want.charge_total == CHARGE_MAX) pinned++;
        if (out_beat.charge_total !== want.charge_total ||
            out_beat.current_used !== want.current_used ||
            out_beat.estimated !== want.estimated)
          note_error($sformatf({"result %0d: want charge %h current %h est %b,",
                                " got charge %h current %h est %b"},
                               results_seen, want.charge_total, want.current_used,
                               want.estimated, out_beat.charge_total,
                               out_beat.current_used, out_beat.estimated));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      totals_due.push_back(tally_charge(in_beat));
      beats_in <= beats_in + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of phases.
  // --------------------------------------------------------------------------
  initial begin : phases
    logic [31:0] gain;
    logic [31:0] thr;
    mdl_ready   = 1'b0;
    mdl_gain    = '0;
    mdl_thr     = '0;
    for (int k = 0; k < 4; k++) mdl_coef[k] = 0;
    mdl_last_ms = '0;
    mdl_charge  = '0;
    stamp       = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: 1 mA/code scaled by half, 100 mA threshold, mixed-sign poly.
    set_regs(32'd1, 32'h0000_8000, 32'h0064_0000, 32'h0002_0000,
             32'h0000_4000, 32'hFFFF_FF00, 32'h0000_0001);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);       // must not disturb anything
    queue_beat(32'd5, 12'd0, 8'd0);            // first beat counts from zero
    queue_beat(32'd25, 12'd4095, 8'd255);      // full-scale code, measured
    queue_beat(32'd25, 12'd100, 8'd128);       // zero elapsed time
    queue_beat(32'd1000, 12'd199, 8'd255);     // just under threshold
    queue_beat(32'd1010, 12'd200, 8'd255);     // exactly at threshold
    queue_beat(32'hFFFF_FFFF, 12'd10, 8'd0);   // long gap to top of range
    queue_beat(32'h0000_0000, 12'd10, 8'd1);   // timestamp wraps
    queue_beat(32'h0000_0020, 12'd4095, 8'd0);
    queue_beat(32'h0000_0010, 12'd0, 8'd255);  // time goes backward
    queue_beat(32'h0000_0030, 12'hAAA, 8'h55);
    queue_beat(32'h0000_0040, 12'h555, 8'hAA);
    settle();

    // model off: below-threshold codes still use the measurement
    set_regs(32'd0, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0002_0000,
             32'h0000_4000, 32'hFFFF_FF00, 32'h0000_0001);
    queue_beat(32'h0000_0048, 12'd0, 8'd0);
    queue_beat(32'h0000_0050, 12'd4095, 8'd255);
    settle();

    // polynomial extremes: top-end saturation at full duty
    set_regs(32'd1, 32'h0000_8000, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
    queue_beat(32'h0000_0051, 12'd0, 8'd255);
    queue_beat(32'h0000_0052, 12'd0, 8'd1);
    queue_beat(32'h0000_0053, 12'd4095, 8'd0);
    settle();

    // negative cubic term drives the estimate below zero
    set_regs(32'd1, 32'h0000_8000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
             32'd0, 32'd0, 32'h8000_0000);
    queue_beat(32'h0000_0054, 12'd0, 8'd255);
    queue_beat(32'h0000_0055, 12'd0, 8'd0);
    settle();
    stamp = 32'h0000_0055;

    // Random: max gain, zero threshold, model off (long hold-off lands here)
    set_regs(32'd0, 32'h00FF_FFFF, 32'd0, $urandom, $urandom, $urandom, $urandom);
    queue_run(100, 64, 0);
    settle();

    // model on, threshold inside the measured range, moderate coefficients
    repeat (2) begin
      gain = $urandom_range(1, 32'h0003_FFFF);
      thr  = $urandom_range(4095) * gain;
      set_regs(32'd1, gain, thr,
               int'($urandom) >>> $urandom_range(8, 30),
               int'($urandom) >>> $urandom_range(8, 30),
               int'($urandom) >>> $urandom_range(8, 30),
               int'($urandom) >>> $urandom_range(8, 30));
      queue_run(70, 64, 0);
      settle();
    end

    // zero gain: every beat estimated, full-range coefficients
    set_regs(32'd1, 32'd0, 32'd1, $urandom, $urandom, $urandom, $urandom);
    queue_run(100, 64, 0);
    settle();

    // small gain, model off, some wild timestamp jumps
    set_regs(32'd0, $urandom_range(1, 255), 32'hFFFF_FFFF,
             $urandom, $urandom, $urandom, $urandom);
    queue_run(100, 64, 10);
    settle();

    // charge saturation: a huge jump pins the total, which then stays put
    set_regs(32'd0, 32'h00FF_FFFF, 32'd0, $urandom, $urandom, $urandom, $urandom);
    stamp = stamp + 32'h8000_0000;
    queue_beat(stamp, 12'd4095, 8'd128);
    queue_run(40, 64, 5);
    settle();

    $display("summary: %0d input beats, %0d results checked, %0d from the duty model",
             beats_in, results_seen, from_model);
    $display("summary: %0d results at full-scale charge, %0d mismatches",
             pinned, mismatches);
    if (mismatches == 0 && totals_due.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
